// File: sv/bdc_pkg.sv
// Package for the byte deque with cursor: sizes, command and status codes.
`default_nettype none
package bdc_pkg;
    localparam int CAPACITY = 64;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = IDX_W + 1;
    localparam int BYTE_W   = 8;
    localparam int CMD_W    = 4;
    localparam int ST_W     = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH_REAR   = 4'd0,
        CMD_POP_FRONT   = 4'd1,
        CMD_POP_REAR    = 4'd2,
        CMD_PEEK_FRONT  = 4'd3,
        CMD_PEEK_REAR   = 4'd4,
        CMD_CURSOR_NEXT = 4'd5,
        CMD_CURSOR_PREV = 4'd6,
        CMD_CURSOR_FRONT = 4'd7,
        CMD_CURSOR_REAR = 4'd8
    } t_cmd;

    typedef enum logic [ST_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_END   = 2'd3
    } t_status;
endpackage
`default_nettype wire

// File: sv/bdc_ram.sv
// Generic single-write, single-read RAM with registered, enabled read.
`default_nettype none
module bdc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_we,
    input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                 i_wdata,
    input  wire logic                             i_re,
    input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                 o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule
`default_nettype wire

// File: sv/byte_deque_with_cursor_top.sv
// Byte deque with browsing cursor: ring storage in one RAM, index registers, output register.
//
//  channel  | valid       | ready       | payload
//  ---------+-------------+-------------+----------------------------
//  input    | i_in_valid  | o_in_ready  | i_command, i_push_byte
//  output   | o_out_valid | i_out_ready | o_read_byte, o_status
//
// One item per cycle sustained while the output side takes results; the RAM read port is used at most once per item.
// o_out_valid rises once the item has passed the RAM read into stage one (at the accepting
// edge) and then moved into the output register; a stalled result there can hold it back.
// An item may be accepted while a finished result waits; input stalls only when both
// the read stage and the output register are full.
// Synchronous reset clears the indices and valid flags; the RAM needs no clearing pass.
`default_nettype none
module byte_deque_with_cursor_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [3:0]  i_command,
    input  wire logic [7:0]  i_push_byte,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [7:0]       o_read_byte,
    output logic [1:0]       o_status
);
    localparam int IDX_W = bdc_pkg::IDX_W;
    localparam int CNT_W = bdc_pkg::CNT_W;

    logic [IDX_W-1:0] r_front, n_front;
    logic [CNT_W-1:0] r_count, n_count;
    logic [IDX_W-1:0] r_cursor, n_cursor;

    logic              r_s1_valid;
    logic              r_s1_use, n_s1_use;
    bdc_pkg::t_status  r_s1_status, n_s1_status;

    logic              r_out_valid;
    logic [7:0]        r_out_byte;
    bdc_pkg::t_status  r_out_status;

    logic              in_fire, s1_move;
    logic              ram_we, ram_re;
    logic [IDX_W-1:0]  off_sel, addr;
    logic [CNT_W-1:0]  pos_sum, cnt_dec, cnt_dec2, cur_inc;
    logic [IDX_W-1:0]  front_inc;
    logic [7:0]        ram_rdata;
    logic              empty, full;

    assign s1_move    = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || s1_move;
    assign in_fire    = i_in_valid && o_in_ready;

    assign empty     = (r_count == '0);
    assign full      = (r_count == CNT_W'(bdc_pkg::CAPACITY));
    assign cnt_dec   = r_count - CNT_W'(1);
    assign cnt_dec2  = r_count - CNT_W'(2);
    assign cur_inc   = {1'b0, r_cursor} + CNT_W'(1);
    assign front_inc = (r_front == IDX_W'(bdc_pkg::CAPACITY - 1)) ? '0 : r_front + IDX_W'(1);

    always_comb begin
        pos_sum = {1'b0, r_front} + {1'b0, off_sel};
        if (pos_sum >= CNT_W'(bdc_pkg::CAPACITY)) begin
            pos_sum = pos_sum - CNT_W'(bdc_pkg::CAPACITY);
        end
        addr = pos_sum[IDX_W-1:0];
    end

    always_comb begin
        n_front     = r_front;
        n_count     = r_count;
        n_cursor    = r_cursor;
        n_s1_use    = 1'b0;
        n_s1_status = bdc_pkg::ST_OK;
        ram_we      = 1'b0;
        ram_re      = 1'b0;
        off_sel     = '0;
        if (in_fire) begin
            unique case (i_command)
                bdc_pkg::CMD_PUSH_REAR: begin
                    off_sel = r_count[IDX_W-1:0];
                    if (full) begin
                        n_s1_status = bdc_pkg::ST_FULL;
                    end else begin
                        ram_we  = 1'b1;
                        n_count = r_count + CNT_W'(1);
                        if (empty) begin
                            n_cursor = '0;
                        end
                    end
                end
                bdc_pkg::CMD_POP_FRONT: begin
                    if (empty) begin
                        n_s1_status = bdc_pkg::ST_EMPTY;
                    end else begin
                        ram_re   = 1'b1;
                        n_s1_use = 1'b1;
                        n_front  = front_inc;
                        n_count  = cnt_dec;
                        if (r_cursor != '0) begin
                            n_cursor = r_cursor - IDX_W'(1);
                        end
                        if (cnt_dec == '0) begin
                            n_cursor = '0;
                        end
                    end
                end
                bdc_pkg::CMD_POP_REAR: begin
                    off_sel = cnt_dec[IDX_W-1:0];
                    if (empty) begin
                        n_s1_status = bdc_pkg::ST_EMPTY;
                    end else begin
                        ram_re   = 1'b1;
                        n_s1_use = 1'b1;
                        n_count  = cnt_dec;
                        if (cnt_dec == '0) begin
                            n_cursor = '0;
                        end else if ({1'b0, r_cursor} >= cnt_dec) begin
                            n_cursor = cnt_dec2[IDX_W-1:0];
                        end
                    end
                end
                bdc_pkg::CMD_PEEK_FRONT, bdc_pkg::CMD_PEEK_REAR: begin
                    off_sel = (i_command == bdc_pkg::CMD_PEEK_FRONT) ? '0 : cnt_dec[IDX_W-1:0];
                    if (empty) begin
                        n_s1_status = bdc_pkg::ST_EMPTY;
                    end else begin
                        ram_re   = 1'b1;
                        n_s1_use = 1'b1;
                    end
                end
                bdc_pkg::CMD_CURSOR_NEXT, bdc_pkg::CMD_CURSOR_PREV,
                bdc_pkg::CMD_CURSOR_FRONT, bdc_pkg::CMD_CURSOR_REAR: begin
                    if (empty) begin
                        n_cursor    = '0;
                        n_s1_status = bdc_pkg::ST_EMPTY;
                    end else if (i_command == bdc_pkg::CMD_CURSOR_NEXT) begin
                        off_sel = cur_inc[IDX_W-1:0];
                        if (cur_inc < r_count) begin
                            n_cursor = cur_inc[IDX_W-1:0];
                            ram_re   = 1'b1;
                            n_s1_use = 1'b1;
                        end else begin
                            n_s1_status = bdc_pkg::ST_END;
                        end
                    end else if (i_command == bdc_pkg::CMD_CURSOR_PREV) begin
                        off_sel = r_cursor - IDX_W'(1);
                        if (r_cursor != '0) begin
                            n_cursor = r_cursor - IDX_W'(1);
                            ram_re   = 1'b1;
                            n_s1_use = 1'b1;
                        end else begin
                            n_s1_status = bdc_pkg::ST_END;
                        end
                    end else if (i_command == bdc_pkg::CMD_CURSOR_FRONT) begin
                        n_cursor = '0;
                    end else begin
                        n_cursor = cnt_dec[IDX_W-1:0];
                    end
                end
                default: begin
                end
            endcase
        end
    end

    bdc_ram #(
        .WIDTH (bdc_pkg::BYTE_W),
        .DEPTH (bdc_pkg::CAPACITY)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (addr),
        .i_wdata (i_push_byte),
        .i_re    (ram_re),
        .i_raddr (addr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front     <= '0;
            r_count     <= '0;
            r_cursor    <= '0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_front  <= n_front;
            r_count  <= n_count;
            r_cursor <= n_cursor;
            if (in_fire) begin
                r_s1_valid <= 1'b1;
            end else if (s1_move) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_move) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_use    <= n_s1_use;
            r_s1_status <= n_s1_status;
        end
        if (s1_move) begin
            r_out_byte   <= r_s1_use ? ram_rdata : 8'd0;
            r_out_status <= r_s1_status;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_read_byte = r_out_byte;
    assign o_status    = r_out_status;
endmodule
`default_nettype wire

// File: sv/bdc_checker.sv
// Port-level checker for the byte deque with cursor, bound to the top level.
`default_nettype none
module bdc_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_in_valid,
    input wire logic       o_in_ready,
    input wire logic [3:0] i_command,
    input wire logic [7:0] i_push_byte,
    input wire logic       o_out_valid,
    input wire logic       i_out_ready,
    input wire logic [7:0] o_read_byte,
    input wire logic [1:0] o_status
);
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == bdc_pkg::ST_FULL || o_status == bdc_pkg::ST_EMPTY
                        || o_status == bdc_pkg::ST_END) |-> o_read_byte == 8'd0)
        else $error("error result carries nonzero byte");

    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid && !i_out_ready)
        else $error("input stalled while output side is free");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_read_byte)
                                        && $stable(o_status))
        else $error("stalled item changed");
endmodule

bind byte_deque_with_cursor_top bdc_checker u_bdc_checker (.*);
`default_nettype wire

// File: tb/byte_deque_checker.sv
// Checker for the byte deque with cursor: tracks deque state, predicts each reply, compares.
module byte_deque_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    input  wire logic        i_in_ready,
    input  wire logic [3:0]  i_command,
    input  wire logic [7:0]  i_push_byte,
    input  wire logic        i_out_valid,
    input  wire logic        i_out_ready,
    input  wire logic [7:0]  i_read_byte,
    input  wire logic [1:0]  i_status,
    output int               o_err_count,
    output int               o_pending,
    output int               o_accepted,
    output int               o_checked,
    output int               o_full_hits,
    output int               o_empty_hits,
    output int               o_end_hits
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [bdc_pkg::BYTE_W-1:0] data;
        bdc_pkg::t_status           st;
    } t_deque_reply;

    logic [bdc_pkg::BYTE_W-1:0] ring_mem [bdc_pkg::CAPACITY];
    int unsigned       head_pos;
    int unsigned       held;
    int unsigned       cursor;
    t_deque_reply      expected_replies [$];
    int                errors;
    int                accepted;
    int                checked;
    int                full_hits;
    int                empty_hits;
    int                end_hits;

    initial begin
        head_pos   = 0;
        held       = 0;
        cursor     = 0;
        errors     = 0;
        accepted   = 0;
        checked    = 0;
        full_hits  = 0;
        empty_hits = 0;
        end_hits   = 0;
    end

    function automatic int unsigned slot(int unsigned offset);
        int unsigned p;
        p = head_pos + offset;
        if (p >= bdc_pkg::CAPACITY) begin
            p -= bdc_pkg::CAPACITY;
        end
        return p;
    endfunction

    // Applies one command to the tracked deque and returns the reply it should produce.
    function automatic t_deque_reply apply_command(logic [3:0] cmd, logic [7:0] pb);
        t_deque_reply r;
        r.data = '0;
        r.st   = bdc_pkg::ST_OK;
        case (cmd)
            bdc_pkg::CMD_PUSH_REAR: begin
                if (held >= bdc_pkg::CAPACITY) begin
                    r.st = bdc_pkg::ST_FULL;
                end else begin
                    ring_mem[slot(held)] = pb;
                    if (held == 0) begin
                        cursor = 0;
                    end
                    held++;
                end
            end
            bdc_pkg::CMD_POP_FRONT: begin
                if (held == 0) begin
                    r.st = bdc_pkg::ST_EMPTY;
                end else begin
                    r.data   = ring_mem[slot(0)];
                    head_pos = slot(1);
                    held--;
                    if (cursor > 0) begin
                        cursor--;
                    end
                    if (held == 0) begin
                        cursor = 0;
                    end
                end
            end
            bdc_pkg::CMD_POP_REAR: begin
                if (held == 0) begin
                    r.st = bdc_pkg::ST_EMPTY;
                end else begin
                    r.data = ring_mem[slot(held - 1)];
                    held--;
                    if (held == 0) begin
                        cursor = 0;
                    end else if (cursor >= held) begin
                        cursor = held - 1;
                    end
                end
            end
            bdc_pkg::CMD_PEEK_FRONT, bdc_pkg::CMD_PEEK_REAR: begin
                if (held == 0) begin
                    r.st = bdc_pkg::ST_EMPTY;
                end else begin
                    r.data = ring_mem[slot((cmd == bdc_pkg::CMD_PEEK_FRONT) ? 0 : held - 1)];
                end
            end
            bdc_pkg::CMD_CURSOR_NEXT, bdc_pkg::CMD_CURSOR_PREV,
            bdc_pkg::CMD_CURSOR_FRONT, bdc_pkg::CMD_CURSOR_REAR: begin
                if (held == 0) begin
                    cursor = 0;
                    r.st   = bdc_pkg::ST_EMPTY;
                end else if (cmd == bdc_pkg::CMD_CURSOR_NEXT) begin
                    if (cursor + 1 < held) begin
                        cursor++;
                        r.data = ring_mem[slot(cursor)];
                    end else begin
                        r.st = bdc_pkg::ST_END;
                    end
                end else if (cmd == bdc_pkg::CMD_CURSOR_PREV) begin
                    if (cursor > 0) begin
                        cursor--;
                        r.data = ring_mem[slot(cursor)];
                    end else begin
                        r.st = bdc_pkg::ST_END;
                    end
                end else if (cmd == bdc_pkg::CMD_CURSOR_FRONT) begin
                    cursor = 0;
                end else begin
                    cursor = held - 1;
                end
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    task automatic report(input string msg);
        errors++;
        $display("[%0t] MISMATCH: %s", $realtime, msg);
    endtask

    always @(posedge i_clk) begin
        t_deque_reply want;
        if (!i_rst_n) begin
            head_pos = 0;
            held     = 0;
            cursor   = 0;
            expected_replies.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (expected_replies.size() == 0) begin
                    report($sformatf("reply data %02h status %0d with no command outstanding",
                                     i_read_byte, i_status));
                end else begin
                    want = expected_replies.pop_front();
                    checked++;
                    if (i_read_byte !== want.data) begin
                        report($sformatf("reply %0d read_byte %02h, want %02h",
                                         checked, i_read_byte, want.data));
                    end
                    if (i_status !== want.st) begin
                        report($sformatf("reply %0d status %0d, want %s",
                                         checked, i_status, want.st.name()));
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                want = apply_command(i_command, i_push_byte);
                accepted++;
                case (want.st)
                    bdc_pkg::ST_FULL:  full_hits++;
                    bdc_pkg::ST_EMPTY: empty_hits++;
                    bdc_pkg::ST_END:   end_hits++;
                    default: begin
                    end
                endcase
                expected_replies.push_back(want);
            end
        end
        o_err_count  <= errors;
        o_pending    <= expected_replies.size();
        o_accepted   <= accepted;
        o_checked    <= checked;
        o_full_hits  <= full_hits;
        o_empty_hits <= empty_hits;
        o_end_hits   <= end_hits;
    end
endmodule

// File: tb/tb_byte_deque_with_cursor_top.sv
// Testbench top for the byte deque with cursor: clock, reset, command stimulus, verdict.
module tb_byte_deque_with_cursor_top;
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum int {
        MIX_FILL,
        MIX_DRAIN,
        MIX_BROWSE,
        MIX_ANY
    } t_mix;

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_PERIODIC,
        RX_RANDOM,
        RX_BURSTY
    } t_rx_mode;

    localparam logic [bdc_pkg::CMD_W-1:0] CMD_UNUSED_LO =
        4'(int'(bdc_pkg::CMD_CURSOR_REAR) + 1);
    localparam logic [bdc_pkg::CMD_W-1:0] CMD_UNUSED_HI = '1;
    localparam int RANDOM_ITEMS = 1000;
    localparam int DRAIN_LIMIT  = 5000;

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_in_valid  = 1'b0;
    logic [3:0] i_command   = '0;
    logic [7:0] i_push_byte = '0;
    logic       i_out_ready = 1'b0;
    wire logic       o_in_ready;
    wire logic       o_out_valid;
    wire logic [7:0] o_read_byte;
    wire logic [1:0] o_status;

    int err_count;
    int pending;
    int accepted;
    int checked;
    int full_hits;
    int empty_hits;
    int end_hits;

    t_rx_mode    rx_mode = RX_OPEN;
    int unsigned rx_left = 0;
    logic [7:0]  rx_tick = '0;

    byte_deque_with_cursor_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_command   (i_command),
        .i_push_byte (i_push_byte),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_read_byte (o_read_byte),
        .o_status    (o_status)
    );

    byte_deque_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_ready   (o_in_ready),
        .i_command    (i_command),
        .i_push_byte  (i_push_byte),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_read_byte  (o_read_byte),
        .i_status     (o_status),
        .o_err_count  (err_count),
        .o_pending    (pending),
        .o_accepted   (accepted),
        .o_checked    (checked),
        .o_full_hits  (full_hits),
        .o_empty_hits (empty_hits),
        .o_end_hits   (end_hits)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #3ms;
        $display("DONE: errors detected");
        $finish;
    end

    // Receiver: switches between open, periodic, random and long-stall patterns.
    always @(posedge i_clk) begin
        rx_tick <= rx_tick + 1'b1;
        if (rx_left == 0) begin
            rx_mode <= t_rx_mode'($urandom_range(0, 3));
            rx_left <= $urandom_range(40, 200);
        end else begin
            rx_left <= rx_left - 1;
        end
        case (rx_mode)
            RX_OPEN:     i_out_ready <= 1'b1;
            RX_PERIODIC: i_out_ready <= (rx_tick[2:0] != 3'd5) && (rx_tick[2:0] != 3'd6);
            RX_RANDOM:   i_out_ready <= 1'($urandom_range(0, 1));
            default:     i_out_ready <= (rx_tick[4:3] == 2'b00);
        endcase
    end

    task automatic send_item(input logic [3:0] cmd, input logic [7:0] pb);
        i_in_valid  <= 1'b1;
        i_command   <= cmd;
        i_push_byte <= pb;
        @(posedge i_clk);
        while (!o_in_ready) begin
            @(posedge i_clk);
        end
    endtask

    task automatic pause_sender(input int unsigned cycles);
        i_in_valid <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    function automatic logic [3:0] pick_command(t_mix mix);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 3) begin
            return 4'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));
        end
        case (mix)
            MIX_FILL: begin
                if (r < 85) begin
                    return bdc_pkg::CMD_PUSH_REAR;
                end
                return 4'($urandom_range(bdc_pkg::CMD_POP_FRONT, bdc_pkg::CMD_CURSOR_REAR));
            end
            MIX_DRAIN: begin
                if (r < 70) begin
                    return ($urandom_range(0, 1) != 0) ? bdc_pkg::CMD_POP_FRONT
                                                       : bdc_pkg::CMD_POP_REAR;
                end
                return 4'($urandom_range(bdc_pkg::CMD_PUSH_REAR, bdc_pkg::CMD_CURSOR_REAR));
            end
            MIX_BROWSE: begin
                if (r < 18) begin
                    return bdc_pkg::CMD_PUSH_REAR;
                end else if (r < 24) begin
                    return 4'($urandom_range(bdc_pkg::CMD_POP_FRONT, bdc_pkg::CMD_POP_REAR));
                end
                return 4'($urandom_range(bdc_pkg::CMD_PEEK_FRONT, bdc_pkg::CMD_CURSOR_REAR));
            end
            default: return 4'($urandom_range(bdc_pkg::CMD_PUSH_REAR,
                                              bdc_pkg::CMD_CURSOR_REAR));
        endcase
    endfunction

    initial begin
        int unsigned sent;
        int unsigned seg_left;
        int unsigned seg_no;
        int unsigned burst_left;
        int unsigned guard;
        t_mix        mix;
        logic [3:0]  cmd;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty deque: every read and cursor command
        send_item(bdc_pkg::CMD_POP_FRONT, 8'h3C);
        send_item(bdc_pkg::CMD_POP_REAR, 8'hC3);
        send_item(bdc_pkg::CMD_PEEK_FRONT, 8'h00);
        send_item(bdc_pkg::CMD_PEEK_REAR, 8'hFF);
        send_item(bdc_pkg::CMD_CURSOR_NEXT, 8'h55);
        send_item(bdc_pkg::CMD_CURSOR_PREV, 8'hAA);
        send_item(bdc_pkg::CMD_CURSOR_FRONT, 8'h0F);
        send_item(bdc_pkg::CMD_CURSOR_REAR, 8'hF0);
        // push into empty, then walk the cursor past both ends
        send_item(bdc_pkg::CMD_PUSH_REAR, 8'hFF);
        send_item(bdc_pkg::CMD_PUSH_REAR, 8'h00);
        send_item(bdc_pkg::CMD_PUSH_REAR, 8'hA5);
        send_item(bdc_pkg::CMD_CURSOR_PREV, 8'h00);
        send_item(bdc_pkg::CMD_CURSOR_NEXT, 8'h00);
        send_item(bdc_pkg::CMD_CURSOR_NEXT, 8'h00);
        send_item(bdc_pkg::CMD_CURSOR_NEXT, 8'h00);
        send_item(bdc_pkg::CMD_PEEK_FRONT, 8'h00);
        send_item(bdc_pkg::CMD_PEEK_REAR, 8'h00);
        // front pop with cursor elsewhere, rear pop under the cursor
        send_item(bdc_pkg::CMD_POP_FRONT, 8'h00);
        send_item(bdc_pkg::CMD_CURSOR_PREV, 8'h00);
        send_item(bdc_pkg::CMD_CURSOR_REAR, 8'h00);
        send_item(bdc_pkg::CMD_POP_REAR, 8'h00);
        send_item(bdc_pkg::CMD_CURSOR_FRONT, 8'h00);
        send_item(bdc_pkg::CMD_POP_FRONT, 8'h00);
        send_item(CMD_UNUSED_LO, 8'hFF);
        send_item(CMD_UNUSED_HI, 8'hFF);

        // random phase: fill to full, drain to empty, then mixed segments
        sent       = 0;
        seg_no     = 0;
        seg_left   = 120;
        mix        = MIX_FILL;
        burst_left = $urandom_range(1, 24);
        while (sent < RANDOM_ITEMS) begin
            if (seg_left == 0) begin
                seg_no++;
                mix      = (seg_no == 1) ? MIX_DRAIN : t_mix'($urandom_range(0, 3));
                seg_left = (seg_no == 1) ? 120 : $urandom_range(30, 120);
            end
            cmd = pick_command(mix);
            send_item(cmd, 8'($urandom_range(0, 255)));
            seg_left--;
            if (cmd <= bdc_pkg::CMD_CURSOR_REAR) begin
                sent++;
            end
            if (burst_left == 0) begin
                pause_sender($urandom_range(1, 8));
                burst_left = ($urandom_range(0, 9) == 0) ? 150 : $urandom_range(1, 24);
            end else begin
                burst_left--;
            end
        end

        i_in_valid <= 1'b0;
        @(posedge i_clk);
        guard = 0;
        while (pending != 0 && guard < DRAIN_LIMIT) begin
            @(posedge i_clk);
            guard++;
        end
        if (guard >= DRAIN_LIMIT) begin
            $display("DONE: errors detected");
        end else begin
            repeat (16) @(posedge i_clk);
            $display("Ran %0d commands through fill, drain, browse and mixed phases;",
                     accepted);
            $display("%0d replies checked: %0d full, %0d empty, %0d cursor-at-end.",
                     checked, full_hits, empty_hits, end_hits);
            if (err_count == 0 && pending == 0) begin
                $display("DONE: 0 errors");
            end else begin
                $display("DONE: errors detected");
            end
        end
        $finish;
    end
endmodule

// File: files.f
sv/bdc_pkg.sv
sv/bdc_ram.sv
sv/byte_deque_with_cursor_top.sv
sv/bdc_checker.sv
tb/byte_deque_checker.sv
tb/tb_byte_deque_with_cursor_top.sv
